// ===== hw/rtl/tlbt_pkg.sv =====
// Package with the constants and types of the TLB address translator.
`timescale 1ns / 1ps
`default_nettype none
package tlbt_pkg;
    localparam int PAGE_BYTES      = 256;
    localparam int VIRTUAL_PAGES   = 256;
    localparam int PHYSICAL_FRAMES = 128;
    localparam int TLB_ENTRIES     = 16;

    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
    localparam int FRAME_W = $clog2(PHYSICAL_FRAMES);
    localparam int SLOT_W  = $clog2(TLB_ENTRIES);
    localparam int ADDR_W  = 16;
    localparam int PA_W    = 15;
    localparam int CNT_W   = 32;

    typedef logic [ADDR_W-1:0] laddr_t;

    typedef struct packed {
        logic [PA_W-1:0]    physical_address;
        logic [FRAME_W-1:0] frame_number;
        logic               tlb_hit;
        logic               page_fault;
        logic               replaced;
        logic [CNT_W-1:0]   hit_count;
        logic [CNT_W-1:0]   fault_count;
        logic [CNT_W-1:0]   access_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_OWNER,
        ST_VICTIM,
        ST_FINISH,
        ST_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tlbt_if.sv =====
// Valid/ready channel interfaces for addresses and results.
`timescale 1ns / 1ps
`default_nettype none
interface tlbt_in_if;
    logic                 valid;
    logic                 ready;
    tlbt_pkg::laddr_t     logical_address;
    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);
endinterface

interface tlbt_out_if;
    logic                 valid;
    logic                 ready;
    tlbt_pkg::result_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tlb_page_table_lru_translator.sv =====
// Top level of the TLB translator with demand paging and LRU frame replacement.
// One 16-bit logical address is taken per transfer on the in channel; one
// result transfer per address leaves on the out channel.
// The page table, frame owners and frame ages live in synchronous memories
// with a registered read port; the 16-entry TLB is a register array that
// is compared in parallel.
// A TLB hit, page-table hit or free-frame fault passes through the states
// LOOKUP, FINISH and OUT. A fault after all frames are used scans the age
// memory one frame a cycle, then reads the LRU frame's owner and evicts it.
// One address is in work at a time; the next is taken once the result
// register is free again.
// Reset clears the TLB valid bits, counters, fill pointers and then runs a
// clearing pass over every page-table entry, during which no address is
// taken. A stalled receiver holds the result and blocks new input.
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_table_lru_translator (
    input  wire logic clk,
    input  wire logic rst_n,
    tlbt_in_if.sink   in_ch,
    tlbt_out_if.source out_ch
);
    import tlbt_pkg::*;

    // Page table: valid bit plus frame.
    logic [FRAME_W:0]   pt_mem [VIRTUAL_PAGES];
    logic [PAGE_W-1:0]  owner_mem [PHYSICAL_FRAMES];
    logic [CNT_W-1:0]   age_mem [PHYSICAL_FRAMES];

    logic               tv_reg [TLB_ENTRIES];
    logic [PAGE_W-1:0]  tp_reg [TLB_ENTRIES];
    logic [FRAME_W-1:0] tf_reg [TLB_ENTRIES];

    state_t             st_reg, st_next;
    logic               clr_reg;
    logic [PAGE_W-1:0]  clr_idx_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [SLOT_W-1:0]  fill_reg;
    logic [FRAME_W:0]   free_reg;
    logic [CNT_W-1:0]   clock_reg, hit_reg, fault_reg, acc_reg;
    logic [FRAME_W:0]   pt_rd_reg;
    logic [PAGE_W-1:0]  own_rd_reg;
    logic [CNT_W-1:0]   age_rd_reg;
    logic [FRAME_W-1:0] scan_reg;      // address sent to the age memory
    logic [FRAME_W:0]   cmp_idx_reg;   // index whose age arrives this cycle
    logic               cmp_vld_reg;
    logic [FRAME_W-1:0] lru_reg;
    logic [CNT_W-1:0]   lru_age_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               hit_f_reg, fault_f_reg, evict_f_reg;
    logic               out_vld_reg;
    result_t            res_reg;

    logic               tlb_match;
    logic [FRAME_W-1:0] tlb_frame;
    logic               pt_we, own_we, age_we;
    logic [PAGE_W-1:0]  pt_wa;
    logic [FRAME_W:0]   pt_wd;
    logic [FRAME_W-1:0] age_ra;

    always_comb
    begin
        tlb_match = 1'b0;
        tlb_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tv_reg[i] && tp_reg[i] == page_reg)
            begin
                tlb_match = 1'b1;
                tlb_frame = tf_reg[i];
            end
        end
    end

    assign in_ch.ready = (st_reg == ST_IDLE) && !clr_reg && !out_vld_reg;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.data = res_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:   if (in_ch.valid && in_ch.ready) st_next = ST_LOOKUP;
            ST_LOOKUP:
            begin
                if (tlb_match || pt_rd_reg[FRAME_W] || !free_reg[FRAME_W])
                    st_next = ST_FINISH;
                else
                    st_next = ST_SCAN;
            end
            ST_SCAN:
                if (cmp_vld_reg && cmp_idx_reg == (FRAME_W + 1)'(PHYSICAL_FRAMES - 1))
                    st_next = ST_OWNER;
            // ST_OWNER waits for the registered owner read of the final LRU frame.
            ST_OWNER:  st_next = ST_VICTIM;
            ST_VICTIM: st_next = ST_FINISH;
            ST_FINISH: st_next = ST_OUT;
            ST_OUT:    st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    // Memory write controls.
    always_comb
    begin
        pt_we  = 1'b0;
        pt_wa  = page_reg;
        pt_wd  = {1'b1, frame_reg};
        own_we = 1'b0;
        age_we = 1'b0;
        age_ra = scan_reg;
        if (clr_reg)
        begin
            pt_we = 1'b1;
            pt_wa = clr_idx_reg;
            pt_wd = '0;
        end
        else if (st_reg == ST_VICTIM)
        begin
            pt_we = 1'b1;
            pt_wa = own_rd_reg;
            pt_wd = '0;
        end
        else if (st_reg == ST_FINISH)
        begin
            pt_we  = fault_f_reg;
            own_we = fault_f_reg;
            age_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_wa] <= pt_wd;
        pt_rd_reg <= pt_mem[(st_reg == ST_IDLE) ? in_ch.logical_address[OFF_W +: PAGE_W]
                                                : page_reg];
        if (own_we)
            owner_mem[frame_reg] <= page_reg;
        own_rd_reg <= owner_mem[lru_reg];
        if (age_we)
            age_mem[frame_reg] <= clock_reg;
        age_rd_reg <= age_mem[age_ra];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE)
        begin
            page_reg <= in_ch.logical_address[OFF_W +: PAGE_W];
            off_reg  <= in_ch.logical_address[OFF_W-1:0];
        end
        if (st_reg == ST_SCAN && cmp_vld_reg)
        begin
            if (cmp_idx_reg == '0 || age_rd_reg < lru_age_reg)
            begin
                lru_reg     <= cmp_idx_reg[FRAME_W-1:0];
                lru_age_reg <= age_rd_reg;
            end
        end
        if (st_reg == ST_LOOKUP)
        begin
            hit_f_reg   <= tlb_match;
            fault_f_reg <= !tlb_match && !pt_rd_reg[FRAME_W];
            evict_f_reg <= !tlb_match && !pt_rd_reg[FRAME_W] && free_reg[FRAME_W];
            if (tlb_match)
                frame_reg <= tlb_frame;
            else if (pt_rd_reg[FRAME_W])
                frame_reg <= pt_rd_reg[FRAME_W-1:0];
            else
                frame_reg <= free_reg[FRAME_W-1:0];
        end
        if (st_reg == ST_VICTIM)
            frame_reg <= lru_reg;
        if (st_reg == ST_OUT)
        begin
            res_reg.physical_address <= PA_W'({frame_reg, off_reg});
            res_reg.frame_number     <= frame_reg;
            res_reg.tlb_hit          <= hit_f_reg;
            res_reg.page_fault       <= fault_f_reg;
            res_reg.replaced         <= evict_f_reg;
            res_reg.hit_count        <= hit_reg;
            res_reg.fault_count      <= fault_reg;
            res_reg.access_count     <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            fill_reg    <= '0;
            free_reg    <= '0;
            clock_reg   <= '0;
            hit_reg     <= '0;
            fault_reg   <= '0;
            acc_reg     <= '0;
            scan_reg    <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tv_reg[i] <= 1'b0;
                tp_reg[i] <= '0;
                tf_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == PAGE_W'(VIRTUAL_PAGES - 1))
                    clr_reg <= 1'b0;
            end
            if (out_vld_reg && out_ch.ready)
                out_vld_reg <= 1'b0;
            if (st_reg == ST_OUT)
                out_vld_reg <= 1'b1;
            // Age scan: address counter runs one index ahead of the compare.
            if (st_reg == ST_LOOKUP)
            begin
                scan_reg    <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (st_reg == ST_SCAN)
            begin
                scan_reg    <= scan_reg + 1'b1;
                cmp_idx_reg <= {1'b0, scan_reg};
                cmp_vld_reg <= 1'b1;
            end
            if (st_reg == ST_LOOKUP)
            begin
                acc_reg <= sat_inc(acc_reg);
                if (tlb_match)
                    hit_reg <= sat_inc(hit_reg);
                else if (!pt_rd_reg[FRAME_W])
                begin
                    fault_reg <= sat_inc(fault_reg);
                    if (!free_reg[FRAME_W])
                        free_reg <= free_reg + 1'b1;
                end
            end
            if (st_reg == ST_VICTIM)
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (tp_reg[i] == own_rd_reg)
                        tv_reg[i] <= 1'b0;
            end
            if (st_reg == ST_FINISH)
            begin
                clock_reg <= sat_inc(clock_reg);
                if (!hit_f_reg)
                begin
                    tv_reg[fill_reg] <= 1'b1;
                    tp_reg[fill_reg] <= page_reg;
                    tf_reg[fill_reg] <= frame_reg;
                    fill_reg         <= fill_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tlbt_checker.sv =====
// Port-level checker for the TLB translator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module tlbt_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire tlbt_pkg::result_t res
);
    import tlbt_pkg::*;

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(res.tlb_hit && res.page_fault)) else $error("hit and fault");
    a_replace_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res.replaced |-> res.page_fault) else $error("replace without fault");
    a_pa_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> res.physical_address[PA_W-1:OFF_W] == res.frame_number)
        else $error("address frame mismatch");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res)) else $error("result dropped");
endmodule

bind tlb_page_table_lru_translator tlbt_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res(out_ch.data)
);
`default_nettype wire

// ===== bench/tb_channels.sv =====
// Bench-side helper interface that carries the cycle counter for the run.
`timescale 1ns / 1ps
interface tb_cycle_if;
    logic [31:0] cycles;
    modport source (output cycles);
    modport sink   (input cycles);
endinterface

// ===== bench/tb.sv =====
// Testbench for the TLB translator: a bit-accurate predictor checks every result.
`timescale 1ns / 1ps
module tb;
    import tlbt_pkg::*;

    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    tlbt_in_if  in_ch ();
    tlbt_out_if out_ch ();
    tb_cycle_if cyc ();

    tlb_page_table_lru_translator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state.
    logic                 pm_valid [VIRTUAL_PAGES];
    logic [FRAME_W-1:0]   pm_frame [VIRTUAL_PAGES];
    logic [PAGE_W-1:0]    owner_of [PHYSICAL_FRAMES];
    logic [31:0]          last_use [PHYSICAL_FRAMES];
    logic                 tl_valid [TLB_ENTRIES];
    logic [PAGE_W-1:0]    tl_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]   tl_frame [TLB_ENTRIES];
    int unsigned          fill_slot;
    int unsigned          frames_used;
    logic [31:0]          use_clk, hits, faults, accesses;

    result_t expected_q[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cyc.cycles);
        errors++;
    endtask

    function automatic void tlb_put(input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] fr);
        tl_valid[fill_slot] = 1'b1;
        tl_page[fill_slot]  = pg;
        tl_frame[fill_slot] = fr;
        fill_slot = (fill_slot + 1) % TLB_ENTRIES;
    endfunction

    function automatic result_t translate(input laddr_t addr);
        result_t r;
        logic [PAGE_W-1:0] pg;
        logic [FRAME_W-1:0] fr;
        logic hit, flt, ev;
        int lru;
        logic [PAGE_W-1:0] victim;
        pg = addr[ADDR_W-1 -: PAGE_W];
        fr = '0; hit = 0; flt = 0; ev = 0;
        accesses = sat_inc(accesses);
        for (int i = 0; i < TLB_ENTRIES; i++)
            if (!hit && tl_valid[i] && tl_page[i] == pg) begin
                hit = 1; fr = tl_frame[i];
            end
        if (hit)
            hits = sat_inc(hits);
        else if (pm_valid[pg])
        begin
            fr = pm_frame[pg];
            tlb_put(pg, fr);
        end
        else
        begin
            flt = 1;
            faults = sat_inc(faults);
            if (frames_used < PHYSICAL_FRAMES)
            begin
                fr = frames_used[FRAME_W-1:0];
                frames_used++;
            end
            else
            begin
                lru = 0;
                for (int i = 1; i < PHYSICAL_FRAMES; i++)
                    if (last_use[i] < last_use[lru]) lru = i;
                victim = owner_of[lru];
                pm_valid[victim] = 1'b0;
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (tl_valid[i] && tl_page[i] == victim) tl_valid[i] = 1'b0;
                fr = lru[FRAME_W-1:0];
                ev = 1;
            end
            pm_valid[pg] = 1'b1;
            pm_frame[pg] = fr;
            owner_of[fr] = pg;
            tlb_put(pg, fr);
        end
        last_use[fr] = use_clk;
        use_clk = sat_inc(use_clk);
        r.physical_address = {fr, addr[OFF_W-1:0]};
        r.frame_number = fr;
        r.tlb_hit = hit;
        r.page_fault = flt;
        r.replaced = ev;
        r.hit_count = hits;
        r.fault_count = faults;
        r.access_count = accesses;
        return r;
    endfunction

    // Cycle counter and timeout.
    initial cyc.cycles = 0;
    always @(posedge clk)
    begin
        cyc.cycles <= cyc.cycles + 1;
        if (cyc.cycles > LIMIT)
        begin
            $display("timeout");
            $display("FAIL tlb_page_table_lru_translator");
            $finish;
        end
    end

    // Result checker.
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                report("unexpected result", 0, 0);
            end
            else
            begin
                result_t e, g;
                e = expected_q.pop_front();
                g = out_ch.data;
                if (g.physical_address !== e.physical_address)
                    report("physical_address", 32'(g.physical_address),
                           32'(e.physical_address));
                if (g.frame_number !== e.frame_number)
                    report("frame_number", 32'(g.frame_number), 32'(e.frame_number));
                if (g.tlb_hit !== e.tlb_hit)
                    report("tlb_hit", 32'(g.tlb_hit), 32'(e.tlb_hit));
                if (g.page_fault !== e.page_fault)
                    report("page_fault", 32'(g.page_fault), 32'(e.page_fault));
                if (g.replaced !== e.replaced)
                    report("replaced", 32'(g.replaced), 32'(e.replaced));
                if (g.hit_count !== e.hit_count) report("hit_count", g.hit_count, e.hit_count);
                if (g.fault_count !== e.fault_count)
                    report("fault_count", g.fault_count, e.fault_count);
                if (g.access_count !== e.access_count)
                    report("access_count", g.access_count, e.access_count);
            end
        end

    // Receiver: random stalls plus a long hold-off on request.
    initial out_ch.ready = 1'b0;
    always @(negedge clk)
        if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Valid stays high into the next call unless the sender idles or the
    // bench drains, so back-to-back items need no gap.
    task automatic send_addr(input laddr_t addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.logical_address <= addr;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_q.push_back(translate(addr));
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
    endtask

    // Extremes, offsets, TLB hit, page-table hit after TLB rollover.
    task automatic test_directed();
        send_addr(16'h0000);
        send_addr(16'hFFFF);
        send_addr(16'h00FF);
        send_addr(16'hFF00);
        send_addr(16'h5AA5);
        send_addr(16'hA55A);
        for (int p = 1; p <= 17; p++)
            send_addr({p[7:0], 8'h3C});
        send_addr(16'h0111);
    endtask

    // Fill every frame, then force evictions including stale TLB victims.
    task automatic test_eviction();
        for (int p = 0; p < 140; p++)
            send_addr({p[7:0] ^ 8'h80, 8'($urandom_range(255))});
        for (int n = 0; n < 60; n++)
            send_addr({8'($urandom_range(255)), 8'($urandom_range(255))});
    endtask

    // Random mix: a small working set favors TLB and table hits.
    task automatic test_random(input int count);
        int hot;
        hot = $urandom_range(255);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(3))
                0: send_addr(16'($urandom_range(16'hFFFF)));
                1: send_addr({hot[7:0] + 8'($urandom_range(7)), 8'($urandom_range(255))});
                2: send_addr({hot[7:0] + 8'($urandom_range(40)), 8'($urandom_range(255))});
                default: hot = $urandom_range(255);
            endcase
        end
    endtask

    // Hold the receiver off long enough that the block backs up its input.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 6; n++)
                send_addr(16'($urandom_range(16'hFFFF)));
        join
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.logical_address = '0;
        for (int i = 0; i < VIRTUAL_PAGES; i++) begin pm_valid[i] = 0; pm_frame[i] = '0; end
        for (int i = 0; i < PHYSICAL_FRAMES; i++) begin owner_of[i] = '0; last_use[i] = '0; end
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tl_valid[i] = 0; tl_page[i] = '0; tl_frame[i] = '0;
        end
        fill_slot = 0; frames_used = 0;
        use_clk = '0; hits = '0; faults = '0; accesses = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 17; recv_idle_pct = 60;
        test_directed();
        test_eviction();
        test_random(650);
        send_idle_pct = 60; recv_idle_pct = 17;
        test_backpressure();
        test_random(650);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(650);
        drain();

        if (errors == 0)
            $display("PASS tlb_page_table_lru_translator");
        else
            $display("FAIL tlb_page_table_lru_translator");
        $finish;
    end
endmodule

// ===== tlb_page_table_lru_translator.f =====
hw/rtl/tlbt_pkg.sv
hw/rtl/tlbt_if.sv
hw/rtl/tlb_page_table_lru_translator.sv
hw/rtl/tlbt_checker.sv
bench/tb_channels.sv
bench/tb.sv
